/* src/dpu_pkg.sv */
// ----------------------------------------------------------------------------
// dpu_pkg
// Shared types and constants of the depth to point unprojection block.
// ----------------------------------------------------------------------------
package dpu_pkg;

  localparam int FRAC       = 20;
  localparam int DIST_SCALE = 1000;
  localparam int DIST_W     = 26;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_FOCAL_X      = 3'd0;
  localparam logic [2:0] CFG_FOCAL_Y      = 3'd1;
  localparam logic [2:0] CFG_CENTRE_X     = 3'd2;
  localparam logic [2:0] CFG_CENTRE_Y     = 3'd3;
  localparam logic [2:0] CFG_RADIAL_K1    = 3'd4;
  localparam logic [2:0] CFG_RADIAL_K2    = 3'd5;
  localparam logic [2:0] CFG_LENS_OFFSET  = 3'd6;
  localparam logic [2:0] CFG_INVALID_CODE = 3'd7;

  typedef struct packed {
    logic [23:0]        focal_x;
    logic [23:0]        focal_y;
    logic [23:0]        centre_x;
    logic [23:0]        centre_y;
    logic signed [23:0] radial_k1;
    logic signed [23:0] radial_k2;
    logic [23:0]        lens_offset;
    logic [15:0]        invalid_depth_code;
  } dpu_cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic              ok;
    logic [DIST_W-1:0] dist_um;
    logic [15:0]       confidence;
    logic [15:0]       intensity;
    logic [9:0]        pixel_row;
    logic [9:0]        pixel_col;
  } dpu_item_t;

  // fields that ride along the back pipeline untouched
  typedef struct packed {
    logic              ok;
    logic [DIST_W-1:0] dist_um;
    logic [15:0]       confidence;
    logic [15:0]       intensity;
  } dpu_side_t;

endpackage

/* src/depth_to_point_unprojection.sv */
// ----------------------------------------------------------------------------
// depth_to_point_unprojection
// Depth pixel to Cartesian point with pinhole model and radial lens
// correction, one pixel per clock while the output takes results.
//
//   channel  dir  fields
//   s_*      in   depth_mm, confidence, intensity, pixel_row, pixel_col
//   m_*      out  point_valid (tuser); x_um, y_um, z_um, confidence_out,
//                 intensity_out (tdata)
//   cfg_*    in   register writes, index 0..7
//
// One pixel accepted per cycle while the queue has room; a result passes
// the 25 stage normalizing dividers, the 31 stage square root and the 26
// stage output dividers. Reset is synchronous and clears only control. A
// stalled output holds the whole geometry pipe; the four entry queue and
// input register keep taking pixels until they fill.
// ----------------------------------------------------------------------------
module depth_to_point_unprojection #(
  parameter int COL_LIMIT = 1024,
  parameter int ROW_LIMIT = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // depth_mm[15:0], confidence[31:16], intensity[47:32],
  // pixel_row[57:48], pixel_col[67:58], zero pad
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // x_um[26:0], y_um[53:27], z_um[80:54], confidence_out[96:81],
  // intensity_out[112:97], zero pad
  output logic [119:0] m_tdata,
  // point_valid[0]
  output logic [0:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  import dpu_pkg::*;

  dpu_cfg_t  cfg;
  logic      head_valid;
  dpu_item_t head;
  logic      pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x            <= 24'd36864;
      cfg.focal_y            <= 24'd36864;
      cfg.centre_x           <= 24'd22528;
      cfg.centre_y           <= 24'd16384;
      cfg.radial_k1          <= 24'sd0;
      cfg.radial_k2          <= 24'sd0;
      cfg.lens_offset        <= 24'd0;
      cfg.invalid_depth_code <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOCAL_X:      cfg.focal_x            <= cfg_data;
        CFG_FOCAL_Y:      cfg.focal_y            <= cfg_data;
        CFG_CENTRE_X:     cfg.centre_x           <= cfg_data;
        CFG_CENTRE_Y:     cfg.centre_y           <= cfg_data;
        CFG_RADIAL_K1:    cfg.radial_k1          <= cfg_data;
        CFG_RADIAL_K2:    cfg.radial_k2          <= cfg_data;
        CFG_LENS_OFFSET:  cfg.lens_offset        <= cfg_data;
        CFG_INVALID_CODE: cfg.invalid_depth_code <= cfg_data[15:0];
      endcase
    end
  end

  dpu_front #(.COL_LIMIT(COL_LIMIT), .ROW_LIMIT(ROW_LIMIT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  dpu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

/* src/dpu_div_pipe.sv */
// ----------------------------------------------------------------------------
// dpu_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a tag
// that travels alongside. Dividend >> QW must be below the divisor.
// ----------------------------------------------------------------------------
module dpu_div_pipe #(
  parameter int DW = 45,
  parameter int VW = 24,
  parameter int QW = 25,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic [TW-1:0] tag_out
);

  logic          st_v   [QW];
  logic [VW-1:0] st_rem [QW];
  logic [QW-1:0] st_lo  [QW];
  logic [QW-1:0] st_q   [QW];
  logic [VW-1:0] st_dvs [QW];
  logic [TW-1:0] st_tag [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          v_src;
    logic [VW-1:0] rem_src;
    logic [QW-1:0] lo_src;
    logic [QW-1:0] q_src;
    logic [VW-1:0] dvs_src;
    logic [TW-1:0] tag_src;
    logic [VW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_src   = in_valid;
      assign rem_src = VW'(dividend >> QW);
      assign lo_src  = dividend[QW-1:0];
      assign q_src   = '0;
      assign dvs_src = divisor;
      assign tag_src = tag_in;
    end else begin : g_next
      assign v_src   = st_v[i-1];
      assign rem_src = st_rem[i-1];
      assign lo_src  = st_lo[i-1];
      assign q_src   = st_q[i-1];
      assign dvs_src = st_dvs[i-1];
      assign tag_src = st_tag[i-1];
    end

    assign trial = {rem_src, lo_src[QW-1]};
    assign ge    = trial >= {1'b0, dvs_src};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[i] <= 1'b0;
      end else if (en) begin
        st_v[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[i] <= ge ? VW'(trial - {1'b0, dvs_src}) : trial[VW-1:0];
        st_lo[i]  <= {lo_src[QW-2:0], 1'b0};
        st_q[i]   <= {q_src[QW-2:0], ge};
        st_dvs[i] <= dvs_src;
        st_tag[i] <= tag_src;
      end
    end
  end

  assign out_valid = st_v[QW-1];
  assign quotient  = st_q[QW-1];
  assign tag_out   = st_tag[QW-1];

endmodule

/* src/dpu_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// dpu_sqrt_pipe
// Pipelined integer square root (floor), one root bit per stage,
// digit-by-digit on pairs of radicand bits, with a travelling tag.
// ----------------------------------------------------------------------------
module dpu_sqrt_pipe #(
  parameter int IW = 62,
  parameter int TW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [IW-1:0]   radicand,
  input  logic [TW-1:0]   tag_in,
  output logic            out_valid,
  output logic [IW/2-1:0] root,
  output logic [TW-1:0]   tag_out
);

  localparam int RW = IW / 2;

  logic          st_v    [RW];
  logic [RW:0]   st_rem  [RW];
  logic [RW-1:0] st_root [RW];
  logic [IW-1:0] st_rad  [RW];
  logic [TW-1:0] st_tag  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic          v_src;
    logic [RW:0]   rem_src;
    logic [RW-1:0] root_src;
    logic [IW-1:0] rad_src;
    logic [TW-1:0] tag_src;
    logic [RW+2:0] trial;
    logic [RW+2:0] test;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_src    = in_valid;
      assign rem_src  = '0;
      assign root_src = '0;
      assign rad_src  = radicand;
      assign tag_src  = tag_in;
    end else begin : g_next
      assign v_src    = st_v[i-1];
      assign rem_src  = st_rem[i-1];
      assign root_src = st_root[i-1];
      assign rad_src  = st_rad[i-1];
      assign tag_src  = st_tag[i-1];
    end

    assign trial = {rem_src, rad_src[IW-1:IW-2]};
    assign test  = {1'b0, root_src, 2'b01};
    assign ge    = trial >= test;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[i] <= 1'b0;
      end else if (en) begin
        st_v[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[i]  <= ge ? (RW+1)'(trial - test) : trial[RW:0];
        st_root[i] <= {root_src[RW-2:0], ge};
        st_rad[i]  <= {rad_src[IW-3:0], 2'b00};
        st_tag[i]  <= tag_src;
      end
    end
  end

  assign out_valid = st_v[RW-1];
  assign root      = st_root[RW-1];
  assign tag_out   = st_tag[RW-1];

endmodule

/* src/dpu_front.sv */
// ----------------------------------------------------------------------------
// dpu_front
// Input register, pixel classification and depth scaling, followed by a
// four entry queue that decouples the input from the geometry pipeline.
// ----------------------------------------------------------------------------
module dpu_front #(
  parameter int COL_LIMIT = 1024,
  parameter int ROW_LIMIT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  dpu_pkg::dpu_cfg_t  cfg,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [71:0]        s_tdata,
  output logic               head_valid,
  output dpu_pkg::dpu_item_t head,
  input  logic               pop
);

  import dpu_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  logic [15:0] depth_mm;
  logic [9:0]  pixel_row;
  logic [9:0]  pixel_col;
  dpu_item_t   in_item;

  logic        fr_v;
  dpu_item_t   fr_item;
  logic        push;

  dpu_item_t      q_mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  assign depth_mm  = s_tdata[15:0];
  assign pixel_row = s_tdata[57:48];
  assign pixel_col = s_tdata[67:58];

  always_comb begin
    in_item.ok = (depth_mm != 16'd0) && (depth_mm != cfg.invalid_depth_code) &&
                 (32'(pixel_row) < ROW_LIMIT) && (32'(pixel_col) < COL_LIMIT);
    in_item.dist_um    = DIST_W'(depth_mm) * DIST_W'(DIST_SCALE);
    in_item.confidence = s_tdata[31:16];
    in_item.intensity  = s_tdata[47:32];
    in_item.pixel_row  = pixel_row;
    in_item.pixel_col  = pixel_col;
  end

  assign push     = fr_v && (count != (QAW+1)'(QDEPTH));
  assign s_tready = !fr_v || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      fr_v <= 1'b1;
    end else if (push) begin
      fr_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      fr_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= fr_item;
    end
  end

  assign head_valid = count != '0;
  assign head       = q_mem[rptr];

endmodule

/* src/dpu_back.sv */
// ----------------------------------------------------------------------------
// dpu_back
// Geometry pipeline: normalize, radial correction, norm by square root,
// scale by depth, and the output register. The whole pipe holds while a
// result waits at the output.
// ----------------------------------------------------------------------------
module dpu_back (
  input  logic               clk,
  input  logic               rst,
  input  dpu_pkg::dpu_cfg_t  cfg,
  input  logic               head_valid,
  input  dpu_pkg::dpu_item_t head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [119:0]       m_tdata,
  output logic [0:0]         m_tuser
);

  import dpu_pkg::*;

  localparam int SW = $bits(dpu_side_t);

  localparam logic [24:0] XN_LIM = 25'd1 << 24;
  localparam logic [36:0] K_LIM  = 37'd1 << 36;
  localparam logic [30:0] XD_LIM = 31'd1 << 30;
  localparam logic [63:0] HALF64 = 64'd1 << (FRAC - 1);
  localparam logic signed [63:0] K_ONE = 64'sd1 <<< (2 * FRAC);

  logic en;
  logic ov;

  // normalization inputs
  logic [23:0] fxe, fye;
  logic [25:0] nx, ny;
  logic [24:0] mx, my;
  logic [44:0] dvx_c, dvy_c;
  dpu_side_t   side_c;

  logic        v0;
  logic [44:0] dvx, dvy;
  logic        ovx0, ovy0, sx0, sy0;
  dpu_side_t   side0;

  logic              dx_v;
  logic [24:0]       qx, qy;
  logic [SW+1:0]     dx_tag;
  logic [1:0]        dy_tag;

  // radial correction stages
  logic        v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13, v14;
  logic [24:0] ax1, ay1, ax2, ay2, ax3, ay3, ax4, ay4, ax5, ay5, ax6, ay6;
  logic [24:0] ax7, ay7, ax8, ay8, ax9, ay9;
  logic        sgx [1:9];
  logic        sgy [1:9];
  dpu_side_t   sd  [1:14];
  logic [49:0] xx2, yy2;
  logic [50:0] r2_sum;
  logic [29:0] r2_3;
  logic [59:0] r2sq;
  logic signed [54:0] k1r2_4, k1r2_5, k1r2_6;
  logic [59:0] r4_sum;
  logic [38:0] r4;
  logic signed [43:0] ph;
  logic signed [44:0] pl;
  logic signed [63:0] ksum;
  logic        ksg;
  logic [62:0] kmag;
  logic [63:0] k_rnd;
  logic [36:0] kk;
  logic        xs10, ys10, xs11, ys11, xs12, ys12, xs13, ys13, xs14, ys14;
  logic [43:0] pxh, pyh;
  logic [42:0] pxl, pyl;
  logic [61:0] px, py;
  logic [61:0] px_rnd, py_rnd;
  logic [30:0] axd, ayd;
  logic [61:0] xd2, yd2;
  logic [56:0] nxm13, nym13, nxm14, nym14;
  logic [61:0] nsum;

  logic                sq_v;
  logic [30:0]         s_root;
  logic [SW+115:0]     sq_tag;
  logic [56:0]         nxm_s, nym_s;
  logic                xs_s, ys_s;
  dpu_side_t           side_s;

  logic        v15;
  logic [56:0] dvdx, dvdy, dvdz;
  logic [30:0] s15;
  logic        xs15, ys15;
  dpu_side_t   side15;

  logic          fx_v;
  logic [25:0]   fqx, fqy, fqz;
  logic [SW+1:0] fx_tag;
  dpu_side_t     side_f;

  logic [25:0] off_um;

  logic [26:0] ox, oy, oz;
  logic [15:0] oconf, ointen;
  logic        opv;

  assign en  = !ov || m_tready;
  assign pop = en && head_valid;

  always_comb begin
    fxe = (cfg.focal_x == 24'd0) ? 24'd1 : cfg.focal_x;
    fye = (cfg.focal_y == 24'd0) ? 24'd1 : cfg.focal_y;
    nx  = {2'b00, cfg.centre_x} - {8'b0, head.pixel_col, 8'b0};
    ny  = {2'b00, cfg.centre_y} - {8'b0, head.pixel_row, 8'b0};
    mx  = nx[25] ? 25'(26'd0 - nx) : nx[24:0];
    my  = ny[25] ? 25'(26'd0 - ny) : ny[24:0];
    dvx_c = {mx, 20'b0} + 45'(fxe[23:1]);
    dvy_c = {my, 20'b0} + 45'(fye[23:1]);
    side_c.ok         = head.ok;
    side_c.dist_um    = head.dist_um;
    side_c.confidence = head.confidence;
    side_c.intensity  = head.intensity;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
      v14 <= 1'b0;
      v15 <= 1'b0;
      ov  <= 1'b0;
    end else if (en) begin
      v0  <= pop;
      v1  <= dx_v;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
      v13 <= v12;
      v14 <= v13;
      v15 <= sq_v;
      ov  <= fx_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvx   <= dvx_c;
      dvy   <= dvy_c;
      ovx0  <= {4'b0, dvx_c[44:25]} >= fxe;
      ovy0  <= {4'b0, dvy_c[44:25]} >= fye;
      sx0   <= nx[25];
      sy0   <= ny[25];
      side0 <= side_c;
    end
  end

  dpu_div_pipe #(.DW(45), .VW(24), .QW(25), .TW(SW + 2)) u_div_xn (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v0),
    .dividend (dvx),
    .divisor  (fxe),
    .tag_in   ({side0, sx0, ovx0}),
    .out_valid(dx_v),
    .quotient (qx),
    .tag_out  (dx_tag)
  );

  dpu_div_pipe #(.DW(45), .VW(24), .QW(25), .TW(2)) u_div_yn (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v0),
    .dividend (dvy),
    .divisor  (fye),
    .tag_in   ({sy0, ovy0}),
    .out_valid(),
    .quotient (qy),
    .tag_out  (dy_tag)
  );

  assign r2_sum = {1'b0, xx2} + {1'b0, yy2} + 51'(HALF64);
  assign r4_sum = r2sq + 60'(HALF64);
  assign k_rnd  = {1'b0, kmag} + HALF64;
  assign px_rnd = px + 62'(HALF64);
  assign py_rnd = py + 62'(HALF64);

  always_ff @(posedge clk) begin
    if (en) begin
      // clamp |xn|, |yn| at 16
      if (dx_tag[0] || (qx > XN_LIM)) begin
        ax1 <= XN_LIM;
      end else begin
        ax1 <= qx;
      end
      if (dy_tag[0] || (qy > XN_LIM)) begin
        ay1 <= XN_LIM;
      end else begin
        ay1 <= qy;
      end
      sgx[1] <= dx_tag[1];
      sgy[1] <= dy_tag[1];
      sd[1]  <= dx_tag[SW+1:2];

      xx2 <= 50'(ax1) * 50'(ax1);
      yy2 <= 50'(ay1) * 50'(ay1);
      ax2 <= ax1;
      ay2 <= ay1;

      r2_3 <= r2_sum[49:20];
      ax3  <= ax2;
      ay3  <= ay2;

      r2sq   <= 60'(r2_3) * 60'(r2_3);
      k1r2_4 <= $signed(cfg.radial_k1) * $signed({1'b0, r2_3});
      ax4    <= ax3;
      ay4    <= ay3;

      r4     <= r4_sum[58:20];
      k1r2_5 <= k1r2_4;
      ax5    <= ax4;
      ay5    <= ay4;

      ph     <= $signed(cfg.radial_k2) * $signed({1'b0, r4[38:20]});
      pl     <= $signed(cfg.radial_k2) * $signed({1'b0, r4[19:0]});
      k1r2_6 <= k1r2_5;
      ax6    <= ax5;
      ay6    <= ay5;

      ksum <= K_ONE + 64'(k1r2_6) + (64'(ph) <<< 20) + 64'(pl);
      ax7  <= ax6;
      ay7  <= ay6;

      ksg  <= ksum[63];
      kmag <= 63'(ksum[63] ? (64'sd0 - ksum) : ksum);
      ax8  <= ax7;
      ay8  <= ay7;

      // clamp k at 65536
      if (k_rnd[63:20] > 44'(K_LIM)) begin
        kk <= K_LIM;
      end else begin
        kk <= k_rnd[56:20];
      end
      ax9    <= ax8;
      ay9    <= ay8;
      sgx[9] <= sgx[8] ^ ksg;
      sgy[9] <= sgy[8] ^ ksg;

      pxh  <= 44'(ax9) * 44'(kk[36:18]);
      pxl  <= 43'(ax9) * 43'(kk[17:0]);
      pyh  <= 44'(ay9) * 44'(kk[36:18]);
      pyl  <= 43'(ay9) * 43'(kk[17:0]);
      xs10 <= sgx[9];
      ys10 <= sgy[9];

      px   <= (62'(pxh) << 18) + 62'(pxl);
      py   <= (62'(pyh) << 18) + 62'(pyl);
      xs11 <= xs10;
      ys11 <= ys10;

      // clamp |xd|, |yd| at 1024
      axd  <= (px_rnd[61:20] > 42'(XD_LIM)) ? XD_LIM : px_rnd[50:20];
      ayd  <= (py_rnd[61:20] > 42'(XD_LIM)) ? XD_LIM : py_rnd[50:20];
      xs12 <= xs11;
      ys12 <= ys11;

      xd2   <= 62'(axd) * 62'(axd);
      yd2   <= 62'(ayd) * 62'(ayd);
      nxm13 <= 57'(axd) * 57'(sd[12].dist_um);
      nym13 <= 57'(ayd) * 57'(sd[12].dist_um);
      xs13  <= xs12;
      ys13  <= ys12;

      nsum  <= xd2 + yd2 + (62'd1 << (2 * FRAC));
      nxm14 <= nxm13;
      nym14 <= nym13;
      xs14  <= xs13;
      ys14  <= ys13;
    end
  end

  // side and sign bits along the stages
  for (genvar i = 2; i <= 8; i++) begin : g_sgn
    always_ff @(posedge clk) begin
      if (en) begin
        sgx[i] <= sgx[i-1];
        sgy[i] <= sgy[i-1];
      end
    end
  end

  for (genvar i = 2; i <= 14; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  dpu_sqrt_pipe #(.IW(62), .TW(SW + 116)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v14),
    .radicand (nsum),
    .tag_in   ({sd[14], xs14, ys14, nxm14, nym14}),
    .out_valid(sq_v),
    .root     (s_root),
    .tag_out  (sq_tag)
  );

  assign nym_s  = sq_tag[56:0];
  assign nxm_s  = sq_tag[113:57];
  assign ys_s   = sq_tag[114];
  assign xs_s   = sq_tag[115];
  assign side_s = sq_tag[SW+115:116];

  always_ff @(posedge clk) begin
    if (en) begin
      dvdx   <= nxm_s + 57'(s_root[30:1]);
      dvdy   <= nym_s + 57'(s_root[30:1]);
      dvdz   <= 57'({side_s.dist_um, 20'b0}) + 57'(s_root[30:1]);
      s15    <= s_root;
      xs15   <= xs_s;
      ys15   <= ys_s;
      side15 <= side_s;
    end
  end

  dpu_div_pipe #(.DW(57), .VW(31), .QW(26), .TW(SW + 2)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v15),
    .dividend (dvdx),
    .divisor  (s15),
    .tag_in   ({side15, xs15, ys15}),
    .out_valid(fx_v),
    .quotient (fqx),
    .tag_out  (fx_tag)
  );

  dpu_div_pipe #(.DW(57), .VW(31), .QW(26), .TW(1)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v15),
    .dividend (dvdy),
    .divisor  (s15),
    .tag_in   (1'b0),
    .out_valid(),
    .quotient (fqy),
    .tag_out  ()
  );

  dpu_div_pipe #(.DW(57), .VW(31), .QW(26), .TW(1)) u_div_z (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v15),
    .dividend (dvdz),
    .divisor  (s15),
    .tag_in   (1'b0),
    .out_valid(),
    .quotient (fqz),
    .tag_out  ()
  );

  assign side_f = fx_tag[SW+1:2];

  // lens offset in micrometres, rounded
  always_ff @(posedge clk) begin
    off_um <= 26'((34'(cfg.lens_offset) * 34'd1000 + 34'd128) >> 8);
  end

  // quotients never exceed the depth, so the outputs cannot overflow
  always_ff @(posedge clk) begin
    if (en) begin
      opv    <= side_f.ok;
      oconf  <= side_f.confidence;
      ointen <= side_f.intensity;
      if (side_f.ok) begin
        ox <= fx_tag[1] ? (27'd0 - {1'b0, fqx}) : {1'b0, fqx};
        oy <= fx_tag[0] ? (27'd0 - {1'b0, fqy}) : {1'b0, fqy};
        oz <= {1'b0, fqz} - {1'b0, off_um};
      end else begin
        ox <= '0;
        oy <= '0;
        oz <= '0;
      end
    end
  end

  assign m_tvalid   = ov;
  assign m_tdata    = {7'b0, ointen, oconf, oz, oy, ox};
  assign m_tuser[0] = opv;

endmodule

/* verif/dpu_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dpu_checker
// Watches the pixel, point and register channels of the unprojection block,
// computes the expected point of every accepted pixel and compares each
// output transaction with the oldest pending point.
// ----------------------------------------------------------------------------
module dpu_checker #(
  parameter int COL_LIMIT = 1024,
  parameter int ROW_LIMIT = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [71:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [119:0] m_tdata,
  input  logic [0:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  output int           fails,
  output int           pending
);

  import dpu_pkg::*;

  typedef struct packed {
    logic        point_valid;
    logic [26:0] x_um;
    logic [26:0] y_um;
    logic [26:0] z_um;
    logic [15:0] confidence_out;
    logic [15:0] intensity_out;
  } point_t;

  localparam longint ONE = longint'(1) << FRAC;
  localparam longint LIM27 = 67108863;

  dpu_cfg_t regs;
  point_t   points_due[$];

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint rshift_round(longint v, int sh);
    longint unsigned m;
    m = (absval(v) + (longint'(1) << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint v_sign(longint n, longint unsigned m);
    return n < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint div_nearest(longint n, longint unsigned d);
    longint unsigned m;
    m = (absval(n) + d / 2) / d;
    return v_sign(n, m);
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [26:0] sat27(longint v);
    if (v > LIM27) v = LIM27;
    if (v < -LIM27 - 1) v = -LIM27 - 1;
    return v[26:0];
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic point_t unproject(logic [71:0] px);
    point_t p;
    logic [15:0] depth;
    logic [9:0] row, col;
    longint unsigned fx, fy, s;
    longint xn, yn, r2, r4, ksum, k, xd, yd, d, off;
    depth = px[15:0];
    row = px[57:48];
    col = px[67:58];
    p = '0;
    p.confidence_out = px[31:16];
    p.intensity_out = px[47:32];
    if (depth == 0 || depth == regs.invalid_depth_code ||
        row >= ROW_LIMIT || col >= COL_LIMIT)
      return p;
    fx = regs.focal_x == 0 ? 1 : regs.focal_x;
    fy = regs.focal_y == 0 ? 1 : regs.focal_y;
    xn = div_nearest((longint'(regs.centre_x) - longint'(col) * 256) * ONE, fx);
    yn = div_nearest((longint'(regs.centre_y) - longint'(row) * 256) * ONE, fy);
    xn = clip(xn, 16 * ONE);
    yn = clip(yn, 16 * ONE);
    r2 = rshift_round(xn * xn + yn * yn, FRAC);
    r4 = rshift_round(r2 * r2, FRAC);
    ksum = (ONE << FRAC) + longint'($signed(regs.radial_k1)) * r2 +
           longint'($signed(regs.radial_k2)) * r4;
    k = clip(rshift_round(ksum, FRAC), 65536 * ONE);
    xd = clip(rshift_round(xn * k, FRAC), 1024 * ONE);
    yd = clip(rshift_round(yn * k, FRAC), 1024 * ONE);
    s = sqrt_floor(longint'(xd * xd) + longint'(yd * yd) + (longint'(1) << (2 * FRAC)));
    d = longint'(depth) * 1000;
    off = (longint'(regs.lens_offset) * 1000 + 128) >> 8;
    p.point_valid = 1'b1;
    p.x_um = sat27(div_nearest(xd * d, s));
    p.y_um = sat27(div_nearest(yd * d, s));
    p.z_um = sat27(div_nearest(d * ONE, s) - off);
    return p;
  endfunction

  assign pending = points_due.size();

  always @(posedge clk) begin
    point_t got, want;
    if (rst) begin
      fails = 0;
      regs.focal_x <= 24'd36864;
      regs.focal_y <= 24'd36864;
      regs.centre_x <= 24'd22528;
      regs.centre_y <= 24'd16384;
      regs.radial_k1 <= '0;
      regs.radial_k2 <= '0;
      regs.lens_offset <= '0;
      regs.invalid_depth_code <= 16'hFFFF;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FOCAL_X:      regs.focal_x <= cfg_data;
          CFG_FOCAL_Y:      regs.focal_y <= cfg_data;
          CFG_CENTRE_X:     regs.centre_x <= cfg_data;
          CFG_CENTRE_Y:     regs.centre_y <= cfg_data;
          CFG_RADIAL_K1:    regs.radial_k1 <= cfg_data;
          CFG_RADIAL_K2:    regs.radial_k2 <= cfg_data;
          CFG_LENS_OFFSET:  regs.lens_offset <= cfg_data;
          CFG_INVALID_CODE: regs.invalid_depth_code <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) points_due.push_back(unproject(s_tdata));
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tdata[26:0], m_tdata[53:27], m_tdata[80:54],
               m_tdata[96:81], m_tdata[112:97]};
        if (points_due.size() == 0) begin
          $error("point transaction with nothing pending");
          fails++;
        end else begin
          want = points_due.pop_front();
          if (got.point_valid !== want.point_valid) begin
            $error("point_valid exp %0d got %0d", want.point_valid, got.point_valid);
            fails++;
          end
          if (got.x_um !== want.x_um) begin
            $error("x_um exp %0d got %0d", $signed(want.x_um), $signed(got.x_um));
            fails++;
          end
          if (got.y_um !== want.y_um) begin
            $error("y_um exp %0d got %0d", $signed(want.y_um), $signed(got.y_um));
            fails++;
          end
          if (got.z_um !== want.z_um) begin
            $error("z_um exp %0d got %0d", $signed(want.z_um), $signed(got.z_um));
            fails++;
          end
          if (got.confidence_out !== want.confidence_out) begin
            $error("confidence_out exp %0d got %0d", want.confidence_out,
                   got.confidence_out);
            fails++;
          end
          if (got.intensity_out !== want.intensity_out) begin
            $error("intensity_out exp %0d got %0d", want.intensity_out,
                   got.intensity_out);
            fails++;
          end
        end
      end
    end
  end

endmodule

/* verif/tb_depth_to_point_unprojection.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_to_point_unprojection
// Drives depth pixels through the unprojection block under several camera
// settings, with random gaps on the input and back-pressure on the output;
// the checker predicts every point and reports mismatches.
// ----------------------------------------------------------------------------
module tb_depth_to_point_unprojection;
  import dpu_pkg::*;

  localparam int PHASES = 6;
  localparam int PIXELS_PER_PHASE = 265;
  localparam int CYCLE_LIMIT = 300000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [71:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [23:0]  cfg_data;
  int           fails;
  int           pending;
  int           cycles;
  int           tx_gap_pct;
  int           rx_stall_pct;
  logic [15:0]  bad_code;

  depth_to_point_unprojection u_dut (.*);

  dpu_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= $urandom_range(99) >= rx_stall_pct;
    end
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_depth_to_point_unprojection NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_camera(logic [23:0] fx, logic [23:0] fy, logic [23:0] cx,
                            logic [23:0] cy, logic [23:0] k1, logic [23:0] k2,
                            logic [23:0] off, logic [15:0] code);
    write_reg(CFG_FOCAL_X, fx);
    write_reg(CFG_FOCAL_Y, fy);
    write_reg(CFG_CENTRE_X, cx);
    write_reg(CFG_CENTRE_Y, cy);
    write_reg(CFG_RADIAL_K1, k1);
    write_reg(CFG_RADIAL_K2, k2);
    write_reg(CFG_LENS_OFFSET, off);
    write_reg(CFG_INVALID_CODE, {8'd0, code});
    bad_code = code;
  endtask

  task automatic send_pixel(logic [15:0] depth, logic [15:0] conf, logic [15:0] inten,
                            logic [9:0] row, logic [9:0] col);
    @(negedge clk);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, col, row, inten, conf, depth};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic random_pixel();
    logic [15:0] depth;
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) depth = 16'd0;
    else if (pick < 16) depth = bad_code;
    else if (pick < 20) depth = 16'hFFFF;
    else if (pick < 40) depth = 16'($urandom_range(1, 9000));
    else depth = 16'($urandom);
    send_pixel(depth, 16'($urandom), 16'($urandom), 10'($urandom), 10'($urandom));
  endtask

  // nothing pending, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FOCAL_X;
    cfg_data = '0;
    tx_gap_pct = 6;
    rx_stall_pct = 52;
    bad_code = 16'hFFFF;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      tx_gap_pct = ph < 2 ? 6 : (ph < 4 ? 52 : 0);
      rx_stall_pct = ph < 2 ? 52 : (ph < 4 ? 6 : 0);
      case (ph)
        0: set_camera(24'd36864, 24'd36864, 24'd22528, 24'd16384, 24'd0, 24'd0,
                      24'd0, 16'hFFFF);
        1: set_camera(24'($urandom_range(20000, 200000)),
                      24'($urandom_range(20000, 200000)),
                      24'($urandom_range(0, 262143)), 24'($urandom_range(0, 262143)),
                      24'($urandom_range(0, 524287) - 262144),
                      24'($urandom_range(0, 131071) - 65536),
                      24'($urandom_range(0, 65535)), 16'($urandom));
        // zero focal lengths and maximal distortion drive every clamp
        2: set_camera(24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF,
                      24'hFFFFFF, 16'd0);
        3: set_camera(24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'h800000, 24'h800000,
                      24'd0, 16'd1);
        default: set_camera(24'($urandom_range(1, 24'hFFFFFF)),
                            24'($urandom_range(1, 300000)),
                            24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                            24'($urandom), 16'($urandom));
      endcase
      if (ph == 0 || ph == 2) begin
        send_pixel(16'd0, 16'hFFFF, 16'd0, 10'd0, 10'd0);
        send_pixel(bad_code, 16'd0, 16'hFFFF, 10'd5, 10'd5);
        send_pixel(16'hFFFF, 16'h1234, 16'h4321, 10'd1023, 10'd1023);
        send_pixel(16'd1, 16'd1, 16'd1, 10'd0, 10'd1023);
        send_pixel(16'hFFFE, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd0);
        send_pixel(16'd1000, 16'd0, 16'd0, 10'd64, 10'd88);
        send_pixel(16'd65000, 16'hAAAA, 16'h5555, 10'd0, 10'd0);
        send_pixel(16'd2, 16'h5555, 16'hAAAA, 10'd512, 10'd511);
        send_pixel(16'd30000, 16'd7, 16'd9, 10'd1023, 10'd512);
        send_pixel(16'd12345, 16'd3, 16'd4, 10'd300, 10'd1000);
      end
      for (int i = 0; i < PIXELS_PER_PHASE; i++) random_pixel();
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("tb_depth_to_point_unprojection OK");
    end else begin
      $display("tb_depth_to_point_unprojection NOT OK");
    end
    $finish;
  end

endmodule

/* depth_to_point_unprojection.f */
src/dpu_pkg.sv
src/dpu_div_pipe.sv
src/dpu_sqrt_pipe.sv
src/dpu_front.sv
src/dpu_back.sv
src/depth_to_point_unprojection.sv
verif/dpu_checker.sv
verif/tb_depth_to_point_unprojection.sv
